@@ src/lsms_pkg.sv @@
// lsms_pkg: shared types, constants and helper functions for the LED strip
// macro sequencer (controller, datapath, top level and checkers).
// No dependencies.
package lsms_pkg;

    // default sizes
    localparam int PROG_DEPTH_DEF = 256;
    localparam int LED_SLOTS_DEF  = 64;

    // fixed field and state widths
    localparam int FUNC_W     = 2;
    localparam int ADDR_W     = 8;
    localparam int BYTE_W     = 8;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 7;
    localparam int LEN_W      = 9;
    localparam int POS_W      = 10;
    localparam int NUM_W      = 14;
    localparam int SUM_W      = 17;
    localparam int DELAY_W    = 24;
    localparam int IDX_W      = 6;
    localparam int COLOR_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [NUM_W-1:0]   NUM_SAT     = 14'd9999;
    localparam logic [DELAY_W-1:0] MS_PER_SEC  = 24'd1000;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 24'd1000;
    localparam logic [COLOR_W-1:0] LEVEL_FULL  = 8'd127;
    localparam logic [COLOR_W-1:0] LEVEL_ORNG  = 8'd82;
    localparam logic [COLOR_W-1:0] LEVEL_PK_G  = 8'd9;
    localparam logic [COLOR_W-1:0] LEVEL_PK_B  = 8'd73;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROG_LEN  = 1'b1;

    // program characters
    localparam logic [7:0] CH_S    = "S";
    localparam logic [7:0] CH_E    = "E";
    localparam logic [7:0] CH_L    = "L";
    localparam logic [7:0] CH_R    = "R";
    localparam logic [7:0] CH_G    = "G";
    localparam logic [7:0] CH_B    = "B";
    localparam logic [7:0] CH_D    = "D";
    localparam logic [7:0] CH_X    = "X";
    localparam logic [7:0] CH_W    = "W";
    localparam logic [7:0] CH_Z    = "Z";
    localparam logic [7:0] CH_A    = "A";
    localparam logic [7:0] CH_C    = "C";
    localparam logic [7:0] CH_O    = "O";
    localparam logic [7:0] CH_N    = "N";
    localparam logic [7:0] CH_STOP = ".";
    localparam logic [7:0] CH_REP  = "*";
    localparam logic [7:0] CH_ZERO = "0";
    localparam logic [7:0] CH_NINE = "9";
    localparam logic [7:0] CH_LR   = "r";
    localparam logic [7:0] CH_LG   = "g";
    localparam logic [7:0] CH_LB   = "b";
    localparam logic [7:0] CH_LW   = "w";
    localparam logic [7:0] CH_LY   = "y";
    localparam logic [7:0] CH_LO   = "o";
    localparam logic [7:0] CH_LP   = "p";
    localparam logic [7:0] CH_LC   = "c";
    localparam logic [7:0] CH_LV   = "v";

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    // what a tick does with the current opcode
    typedef enum logic [2:0] {
        EX_NOP,
        EX_NEXT,
        EX_SPAN,
        EX_WAIT,
        EX_REPEAT
    } exec_class_t;

    // what decode does after fetching an opcode byte
    typedef enum logic [1:0] {
        DC_OTHER,
        DC_NUM,
        DC_LCOL
    } dec_class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EMIT,
        ST_DEC,
        ST_NUM,
        ST_LCOL,
        ST_DONE,
        ST_FRAME
    } state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic tick;
        logic span_setup;
        logic emit_step;
        logic pos_zero;
        logic dec_latch;
        logic num_step;
        logic num_apply;
        logic lcol_apply;
        logic frame_out;
    } cmd_t;

    typedef struct packed {
        exec_class_t exec_class;
        dec_class_t  dec_class;
        logic        dec_ok;
        logic        fb_digit;
        logic        span_more;
        logic        wait_done;
        logic        out_free;
        logic        wrote;
    } status_t;

    typedef struct packed {
        logic               hit;
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
    } preset_t;

    function automatic exec_class_t exec_class_of(input logic [7:0] op);
        exec_class_t c;
        begin
            case (op)
                CH_N, CH_S, CH_E, CH_L, CH_R, CH_G, CH_B, CH_D, CH_X: c = EX_NEXT;
                CH_Z, CH_A, CH_C, CH_O: c = EX_SPAN;
                CH_W:    c = EX_WAIT;
                CH_REP:  c = EX_REPEAT;
                default: c = EX_NOP;
            endcase
            return c;
        end
    endfunction

    function automatic dec_class_t dec_class_of(input logic [7:0] op);
        dec_class_t c;
        begin
            case (op)
                CH_S, CH_E, CH_R, CH_G, CH_B, CH_D, CH_X: c = DC_NUM;
                CH_L:    c = DC_LCOL;
                default: c = DC_OTHER;
            endcase
            return c;
        end
    endfunction

    function automatic preset_t preset_of(input logic [7:0] ch);
        preset_t p;
        begin
            p = '{hit: 1'b1, r: '0, g: '0, b: '0};
            case (ch)
                CH_LR:   p.r = LEVEL_FULL;
                CH_LG:   p.g = LEVEL_FULL;
                CH_LB:   p.b = LEVEL_FULL;
                CH_LW:   begin p.r = LEVEL_FULL; p.g = LEVEL_FULL; p.b = LEVEL_FULL; end
                CH_LY:   begin p.r = LEVEL_FULL; p.g = LEVEL_FULL; end
                CH_LO:   begin p.r = LEVEL_FULL; p.g = LEVEL_ORNG; end
                CH_LP:   begin p.r = LEVEL_FULL; p.g = LEVEL_PK_G; p.b = LEVEL_PK_B; end
                CH_LC:   begin p.g = LEVEL_FULL; p.b = LEVEL_FULL; end
                CH_LV:   begin p.r = LEVEL_FULL; p.b = LEVEL_FULL; end
                default: p.hit = 1'b0;
            endcase
            return p;
        end
    endfunction

endpackage

@@ src/lsms_ram.sv @@
// lsms_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/lsms_ctrl.sv @@
// lsms_ctrl: sequencing state machine of the LED strip macro sequencer.
// Depends on lsms_pkg; drives datapath commands from datapath status.
module lsms_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic [lsms_pkg::FUNC_W-1:0] s_func,
    output logic                     s_ready,
    output lsms_pkg::cmd_t           cmd,
    input  lsms_pkg::status_t        sts
);
    import lsms_pkg::*;

    state_t state_reg, state_next;
    logic   tick_reg, tick_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tick_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        tick_next  = tick_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (func_t'(s_func))
                        FUNC_LOAD: cmd.load = 1'b1;
                        FUNC_START: begin
                            cmd.start  = 1'b1;
                            tick_next  = 1'b0;
                            state_next = ST_DEC;
                        end
                        FUNC_TICK: begin
                            cmd.tick   = 1'b1;
                            tick_next  = 1'b1;
                            state_next = ST_EXEC;
                        end
                        default: ;
                    endcase
                end
            end
            ST_EXEC: begin
                unique case (sts.exec_class)
                    EX_SPAN: begin
                        cmd.span_setup = 1'b1;
                        state_next     = ST_EMIT;
                    end
                    EX_NEXT: state_next = ST_DEC;
                    EX_REPEAT: begin
                        cmd.pos_zero = 1'b1;
                        state_next   = ST_DEC;
                    end
                    EX_WAIT: state_next = sts.wait_done ? ST_DEC : ST_FRAME;
                    default: state_next = ST_FRAME;
                endcase
            end
            ST_EMIT: begin
                if (!sts.span_more) begin
                    state_next = ST_DEC;
                end else if (sts.out_free) begin
                    cmd.emit_step = 1'b1;
                end
            end
            ST_DEC: begin
                if (!sts.dec_ok) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.dec_latch = 1'b1;
                    unique case (sts.dec_class)
                        DC_NUM:  state_next = ST_NUM;
                        DC_LCOL: state_next = ST_LCOL;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_NUM: begin
                if (sts.fb_digit) begin
                    cmd.num_step = 1'b1;
                end else begin
                    cmd.num_apply = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_LCOL: begin
                cmd.lcol_apply = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                state_next = (tick_reg && !sts.wrote) ? ST_FRAME : ST_IDLE;
            end
            ST_FRAME: begin
                if (sts.out_free) begin
                    cmd.frame_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

@@ src/lsms_dp.sv @@
// lsms_dp: datapath of the LED strip macro sequencer: program RAM, read
// position, number parser, colour/range/delay state and the output register.
// Depends on lsms_pkg and lsms_ram.
module lsms_dp #(
    parameter int PROG_DEPTH = lsms_pkg::PROG_DEPTH_DEF,
    parameter int LED_SLOTS  = lsms_pkg::LED_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lsms_pkg::cmd_t                cmd,
    output lsms_pkg::status_t             sts,
    input  logic [lsms_pkg::ADDR_W-1:0]   s_prog_addr,
    input  logic [lsms_pkg::BYTE_W-1:0]   s_prog_byte,
    input  logic [lsms_pkg::TIME_W-1:0]   s_now_ms,
    input  logic                          cfg_wen,
    input  logic [lsms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsms_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_write_valid,
    output logic [lsms_pkg::IDX_W-1:0]    m_led_index,
    output logic [lsms_pkg::COLOR_W-1:0]  m_red,
    output logic [lsms_pkg::COLOR_W-1:0]  m_green,
    output logic [lsms_pkg::COLOR_W-1:0]  m_blue,
    output logic                          m_last
);
    import lsms_pkg::*;

    localparam int AW = $clog2(PROG_DEPTH);

    // configuration
    logic [COUNT_W-1:0] led_count_reg;
    logic [LEN_W-1:0]   prog_len_reg;

    // sequencer state
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [7:0]         opcode_reg;
    logic [IDX_W-1:0]   rfirst_reg, rlast_reg;
    logic [COLOR_W-1:0] red_reg, green_reg, blue_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [TIME_W-1:0]  wait_begin_reg, now_reg;
    logic               started_reg;
    logic [NUM_W-1:0]   num_reg;
    logic               any_reg;
    logic [COUNT_W-1:0] idx_reg, hi_reg;
    logic               lit_reg;
    logic               wrote_reg;

    // output register
    logic               ov_reg, owv_reg, olast_reg;
    logic [IDX_W-1:0]   oidx_reg;
    logic [COLOR_W-1:0] ored_reg, ogreen_reg, oblue_reg;

    logic [COUNT_W-1:0] cnt;
    logic [LEN_W-1:0]   len;
    logic [BYTE_W-1:0]  rdata, fb;
    logic [3:0]         digit;
    logic [SUM_W-1:0]   num_sum;
    logic [NUM_W-1:0]   num_sat;
    logic [COUNT_W-1:0] idx_inc;
    logic               span_last;
    logic               out_free;
    logic [TIME_W-1:0]  elapsed;
    preset_t            pre;

    // effective strip size and program length
    assign cnt = (led_count_reg < LED_SLOTS) ? led_count_reg : COUNT_W'(LED_SLOTS);
    assign len = (prog_len_reg < PROG_DEPTH) ? prog_len_reg : LEN_W'(PROG_DEPTH);

    // program store, read address follows the next read position
    lsms_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PROG_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.load),
        .waddr (AW'(32'(s_prog_addr) % PROG_DEPTH)),
        .wdata (s_prog_byte),
        .raddr (AW'(pos_next)),
        .rdata (rdata)
    );

    // fetched byte, bytes past the length read as zero
    assign fb = (pos_reg < POS_W'(len)) ? rdata : '0;

    // decimal accumulate with saturation
    assign digit   = 4'(fb - CH_ZERO);
    assign num_sum = SUM_W'({num_reg, 3'b000}) + SUM_W'({num_reg, 1'b0}) + SUM_W'(digit);
    assign num_sat = (num_sum > SUM_W'(NUM_SAT)) ? NUM_SAT : NUM_W'(num_sum);

    // span bookkeeping
    assign idx_inc   = idx_reg + 1'b1;
    assign span_last = !((idx_inc <= hi_reg) && (idx_inc < cnt));
    assign out_free  = !ov_reg || m_ready;
    assign elapsed   = now_reg - wait_begin_reg;
    assign pre       = preset_of(fb);

    // status to controller
    always_comb begin
        sts.exec_class = exec_class_of(opcode_reg);
        sts.dec_class  = dec_class_of(fb);
        sts.dec_ok     = started_reg && (pos_reg < POS_W'(len));
        sts.fb_digit   = (fb >= CH_ZERO) && (fb <= CH_NINE);
        sts.span_more  = (idx_reg <= hi_reg) && (idx_reg < cnt);
        sts.wait_done  = elapsed > TIME_W'(delay_reg);
        sts.out_free   = out_free;
        sts.wrote      = wrote_reg;
    end

    // read position update
    always_comb begin
        pos_next = pos_reg;
        if (cmd.start || cmd.pos_zero) begin
            pos_next = '0;
        end else if (cmd.dec_latch) begin
            if (fb != CH_STOP) begin
                pos_next = pos_reg + 1'b1;
            end
        end else if (cmd.num_step || cmd.lcol_apply) begin
            pos_next = pos_reg + 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_count_reg <= '0;
            prog_len_reg  <= '0;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                CFG_LED_COUNT: led_count_reg <= COUNT_W'(cfg_wdata);
                CFG_PROG_LEN:  prog_len_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            opcode_reg     <= '0;
            rfirst_reg     <= '0;
            rlast_reg      <= '0;
            red_reg        <= LEVEL_FULL;
            green_reg      <= '0;
            blue_reg       <= '0;
            delay_reg      <= DELAY_RESET;
            wait_begin_reg <= '0;
            started_reg    <= 1'b0;
            wrote_reg      <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            if (cmd.start) begin
                started_reg <= 1'b1;
            end
            if (cmd.tick) begin
                wrote_reg <= 1'b0;
            end else if (cmd.emit_step) begin
                wrote_reg <= 1'b1;
            end
            if (cmd.dec_latch) begin
                opcode_reg <= fb;
                if (fb == CH_W) begin
                    wait_begin_reg <= now_reg;
                end
            end
            if (cmd.num_apply && any_reg) begin
                case (opcode_reg)
                    CH_S: begin
                        if (num_reg < NUM_W'(cnt)) begin
                            rfirst_reg <= IDX_W'(num_reg);
                            rlast_reg  <= IDX_W'(num_reg);
                        end
                    end
                    CH_E: begin
                        if (num_reg < NUM_W'(cnt)) begin
                            rlast_reg <= IDX_W'(num_reg);
                        end
                    end
                    CH_R: red_reg   <= COLOR_W'(num_reg);
                    CH_G: green_reg <= COLOR_W'(num_reg);
                    CH_B: blue_reg  <= COLOR_W'(num_reg);
                    CH_D: delay_reg <= DELAY_W'(num_reg) * MS_PER_SEC;
                    CH_X: delay_reg <= DELAY_W'(num_reg);
                    default: ;
                endcase
            end
            if (cmd.lcol_apply && pre.hit) begin
                red_reg   <= pre.r;
                green_reg <= pre.g;
                blue_reg  <= pre.b;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.start || cmd.tick) begin
            now_reg <= s_now_ms;
        end
        if (cmd.dec_latch) begin
            num_reg <= '0;
            any_reg <= 1'b0;
        end else if (cmd.num_step) begin
            num_reg <= num_sat;
            any_reg <= 1'b1;
        end
        if (cmd.span_setup) begin
            if (opcode_reg == CH_Z || opcode_reg == CH_A) begin
                idx_reg <= '0;
                hi_reg  <= cnt - 1'b1;
            end else begin
                idx_reg <= COUNT_W'(rfirst_reg);
                hi_reg  <= COUNT_W'(rlast_reg);
            end
            lit_reg <= (opcode_reg == CH_A) || (opcode_reg == CH_O);
        end else if (cmd.emit_step) begin
            idx_reg <= idx_inc;
        end
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (cmd.emit_step || cmd.frame_out) begin
            ov_reg <= 1'b1;
        end else if (m_ready) begin
            ov_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (cmd.emit_step) begin
            owv_reg    <= 1'b1;
            oidx_reg   <= IDX_W'(idx_reg);
            ored_reg   <= lit_reg ? red_reg   : '0;
            ogreen_reg <= lit_reg ? green_reg : '0;
            oblue_reg  <= lit_reg ? blue_reg  : '0;
            olast_reg  <= span_last;
        end else if (cmd.frame_out) begin
            owv_reg    <= 1'b0;
            oidx_reg   <= '0;
            ored_reg   <= '0;
            ogreen_reg <= '0;
            oblue_reg  <= '0;
            olast_reg  <= 1'b1;
        end
    end

    assign m_valid       = ov_reg;
    assign m_write_valid = owv_reg;
    assign m_led_index   = oidx_reg;
    assign m_red         = ored_reg;
    assign m_green       = ogreen_reg;
    assign m_blue        = oblue_reg;
    assign m_last        = olast_reg;

endmodule

@@ src/led_strip_macro_sequencer.sv @@
// A load writes one program byte; a start fetches the first instruction and its operand,
// a preset letter or a run of digits.
// A tick executes the current opcode, with up to 64 LED writes for a span, then fetches
// the next instruction and its operand; an unknown opcode or a wait still running only
// closes the frame. Output stalls hold the block. Sequential: one item in work at a time.
// Reset (aresetn, synchronous, active low) clears config and state, not the program store.
module led_strip_macro_sequencer #(
    parameter int PROG_DEPTH = lsms_pkg::PROG_DEPTH_DEF,
    parameter int LED_SLOTS  = lsms_pkg::LED_SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [lsms_pkg::FUNC_W-1:0]     s_func,
    input  logic [lsms_pkg::ADDR_W-1:0]     s_prog_addr,
    input  logic [lsms_pkg::BYTE_W-1:0]     s_prog_byte,
    input  logic [lsms_pkg::TIME_W-1:0]     s_now_ms,
    input  logic                            cfg_wen,
    input  logic [lsms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsms_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_write_valid,
    output logic [lsms_pkg::IDX_W-1:0]      m_led_index,
    output logic [lsms_pkg::COLOR_W-1:0]    m_red,
    output logic [lsms_pkg::COLOR_W-1:0]    m_green,
    output logic [lsms_pkg::COLOR_W-1:0]    m_blue,
    output logic                            m_last
);
    import lsms_pkg::*;

    cmd_t    cmd;
    status_t sts;

    // controller
    lsms_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // datapath
    lsms_dp #(
        .PROG_DEPTH (PROG_DEPTH),
        .LED_SLOTS  (LED_SLOTS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_prog_addr   (s_prog_addr),
        .s_prog_byte   (s_prog_byte),
        .s_now_ms      (s_now_ms),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_write_valid (m_write_valid),
        .m_led_index   (m_led_index),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_last        (m_last)
    );

endmodule

@@ src/lsms_checker.sv @@
// lsms_props: port-level assertions for led_strip_macro_sequencer, bound to the top.
// Depends on lsms_pkg.
module lsms_props (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_write_valid,
    input logic [lsms_pkg::IDX_W-1:0]   m_led_index,
    input logic [lsms_pkg::COLOR_W-1:0] m_red,
    input logic [lsms_pkg::COLOR_W-1:0] m_green,
    input logic [lsms_pkg::COLOR_W-1:0] m_blue,
    input logic                         m_last
);
    import lsms_pkg::*;

    // a stalled result holds its index, red level, last flag and write flag
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_led_index) && $stable(m_red)
            && $stable(m_last) && $stable(m_write_valid))
        else $error("stalled result changed");

    // an empty frame mark carries zeros and closes the tick
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_valid |-> m_last && m_led_index == '0 && m_red == '0
            && m_green == '0 && m_blue == '0)
        else $error("bad frame mark");

    // no new item while a tick still has writes to deliver
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input ready during frame");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind led_strip_macro_sequencer lsms_props u_lsms_props (.*);

@@ sim/lsms_checker.sv @@
// lsms_checker: watches the transfer channels and configuration port of the LED
// strip macro sequencer, predicts every LED write and frame mark, and compares.
// Depends on lsms_pkg.
`timescale 1ns / 1ps

module lsms_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [7:0]  s_prog_addr,
    input  logic [7:0]  s_prog_byte,
    input  logic [31:0] s_now_ms,
    input  logic        cfg_wen,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_wdata,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_write_valid,
    input  logic [5:0]  m_led_index,
    input  logic [7:0]  m_red,
    input  logic [7:0]  m_green,
    input  logic [7:0]  m_blue,
    input  logic        m_last,
    output int          errors,
    output int          pending
);
    import lsms_pkg::*;

    typedef struct {
        bit       wv;
        bit [5:0] idx;
        bit [7:0] r;
        bit [7:0] g;
        bit [7:0] b;
        bit       last;
    } led_write_t;

    led_write_t  expected_writes[$];

    // sequencer state mirror
    bit [7:0]    prog_mem[256];
    int unsigned pos;
    bit [7:0]    opc;
    bit [5:0]    rng_first, rng_last;
    bit [7:0]    col_r, col_g, col_b;
    bit [31:0]   delay_ms, wait_start;
    bit          running;
    bit [6:0]    led_count_reg;
    bit [8:0]    prog_len_reg;
    int          n_err = 0;

    function automatic int unsigned len_eff();
        return (prog_len_reg < 256) ? prog_len_reg : 256;
    endfunction

    function automatic int unsigned leds_eff();
        return (led_count_reg < 64) ? led_count_reg : 64;
    endfunction

    function automatic bit [7:0] byte_at(int unsigned p);
        return (p < len_eff()) ? prog_mem[p] : 8'd0;
    endfunction

    function automatic bit is_num(bit [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // consume a digit run, saturating at the number limit
    function automatic bit take_number(output int unsigned v);
        bit seen;
        v = 0;
        seen = 0;
        while (is_num(byte_at(pos))) begin
            v = v * 10 + (byte_at(pos) - CH_ZERO);
            if (v > NUM_SAT) v = NUM_SAT;
            pos++;
            seen = 1;
        end
        return seen;
    endfunction

    function automatic void set_col(bit [7:0] r, bit [7:0] g, bit [7:0] b);
        col_r = r;
        col_g = g;
        col_b = b;
    endfunction

    // fetch the next instruction and apply its operand
    function automatic void fetch_instr(bit [31:0] now);
        int unsigned n;
        bit [7:0]    c;
        if (!running || pos >= len_eff()) return;
        opc = byte_at(pos);
        if (opc == CH_STOP) return;
        pos++;
        case (opc)
            CH_S: if (take_number(n) && n < leds_eff()) begin
                rng_first = n[5:0];
                rng_last = n[5:0];
            end
            CH_E: if (take_number(n) && n < leds_eff()) rng_last = n[5:0];
            CH_L: begin
                c = byte_at(pos);
                pos++;
                case (c)
                    CH_LR: set_col(LEVEL_FULL, 0, 0);
                    CH_LG: set_col(0, LEVEL_FULL, 0);
                    CH_LB: set_col(0, 0, LEVEL_FULL);
                    CH_LW: set_col(LEVEL_FULL, LEVEL_FULL, LEVEL_FULL);
                    CH_LY: set_col(LEVEL_FULL, LEVEL_FULL, 0);
                    CH_LO: set_col(LEVEL_FULL, LEVEL_ORNG, 0);
                    CH_LP: set_col(LEVEL_FULL, LEVEL_PK_G, LEVEL_PK_B);
                    CH_LC: set_col(0, LEVEL_FULL, LEVEL_FULL);
                    CH_LV: set_col(LEVEL_FULL, 0, LEVEL_FULL);
                    default: ;
                endcase
            end
            CH_R: if (take_number(n)) col_r = n[7:0];
            CH_G: if (take_number(n)) col_g = n[7:0];
            CH_B: if (take_number(n)) col_b = n[7:0];
            CH_D: if (take_number(n)) delay_ms = n * 1000;
            CH_X: if (take_number(n)) delay_ms = n;
            CH_W: wait_start = now;
            default: ;
        endcase
    endfunction

    function automatic int write_leds(int unsigned lo, int unsigned hi, bit lit);
        led_write_t w;
        int         k;
        k = 0;
        for (int unsigned i = lo; i <= hi && i < leds_eff(); i++) begin
            w.wv = 1;
            w.idx = i[5:0];
            w.r = lit ? col_r : 8'd0;
            w.g = lit ? col_g : 8'd0;
            w.b = lit ? col_b : 8'd0;
            w.last = 0;
            expected_writes.push_back(w);
            k++;
        end
        return k;
    endfunction

    // one tick: execute the current opcode, then close the frame
    function automatic void run_tick(bit [31:0] now);
        int         k;
        led_write_t mark;
        k = 0;
        case (opc)
            CH_N, CH_S, CH_E, CH_L, CH_R, CH_G, CH_B, CH_D, CH_X: fetch_instr(now);
            CH_Z: begin
                if (leds_eff() > 0) k = write_leds(0, leds_eff() - 1, 0);
                fetch_instr(now);
            end
            CH_A: begin
                if (leds_eff() > 0) k = write_leds(0, leds_eff() - 1, 1);
                fetch_instr(now);
            end
            CH_C: begin
                k = write_leds(rng_first, rng_last, 0);
                fetch_instr(now);
            end
            CH_O: begin
                k = write_leds(rng_first, rng_last, 1);
                fetch_instr(now);
            end
            CH_W: if (now - wait_start > delay_ms) fetch_instr(now);
            CH_REP: begin
                pos = 0;
                fetch_instr(now);
            end
            default: ;
        endcase
        if (k == 0) begin
            mark = '{0, 0, 0, 0, 0, 1};
            expected_writes.push_back(mark);
        end else begin
            expected_writes[$].last = 1;
        end
    endfunction

    function automatic void note_error(string what);
        n_err++;
        if (n_err <= 10) $display("%0t: %s", $realtime, what);
    endfunction

    always @(posedge aclk) begin
        led_write_t e;
        if (!aresetn) begin
            expected_writes.delete();
            pos = 0;
            opc = 0;
            rng_first = 0;
            rng_last = 0;
            set_col(LEVEL_FULL, 0, 0);
            delay_ms = 1000;
            wait_start = 0;
            running = 0;
            led_count_reg = 0;
            prog_len_reg = 0;
        end else begin
            // configuration writes
            if (cfg_wen) begin
                if (cfg_index == CFG_LED_COUNT) led_count_reg = cfg_wdata[6:0];
                else if (cfg_index == CFG_PROG_LEN) prog_len_reg = cfg_wdata;
            end
            // input transfer
            if (s_valid && s_ready) begin
                case (func_t'(s_func))
                    FUNC_LOAD: prog_mem[s_prog_addr] = s_prog_byte;
                    FUNC_START: begin
                        pos = 0;
                        running = 1;
                        fetch_instr(s_now_ms);
                    end
                    FUNC_TICK: run_tick(s_now_ms);
                    default: ;
                endcase
            end
            // result transfer
            if (m_valid && m_ready) begin
                if (expected_writes.size() == 0) begin
                    note_error($sformatf("unexpected result idx %0d rgb %0d,%0d,%0d last %0b",
                        m_led_index, m_red, m_green, m_blue, m_last));
                end else begin
                    e = expected_writes.pop_front();
                    if (m_write_valid !== e.wv || m_led_index !== e.idx || m_red !== e.r ||
                        m_green !== e.g || m_blue !== e.b || m_last !== e.last)
                        note_error($sformatf(
                            "exp wv %0b idx %0d rgb %0d,%0d,%0d last %0b / got wv %0b idx %0d rgb %0d,%0d,%0d last %0b",
                            e.wv, e.idx, e.r, e.g, e.b, e.last, m_write_valid, m_led_index,
                            m_red, m_green, m_blue, m_last));
                end
            end
        end
        errors <= n_err;
        pending <= expected_writes.size();
    end

endmodule

@@ sim/led_strip_macro_sequencer_tb.sv @@
// led_strip_macro_sequencer_tb: clock, reset and stimulus for the LED strip
// macro sequencer; checking is done by lsms_checker. Depends on lsms_pkg.
`timescale 1ns / 1ps

module led_strip_macro_sequencer_tb;
    import lsms_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 100;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_func = FUNC_LOAD;
    logic [7:0]  s_prog_addr = 0;
    logic [7:0]  s_prog_byte = 0;
    logic [31:0] s_now_ms = 0;
    logic        cfg_wen = 0;
    logic        cfg_index = CFG_LED_COUNT;
    logic [8:0]  cfg_wdata = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic        m_write_valid;
    logic [5:0]  m_led_index;
    logic [7:0]  m_red, m_green, m_blue;
    logic        m_last;
    int          errors, pending;

    bit          quiet = 0;
    bit          hold_req = 0;
    int          hold_left = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    bit [31:0]   now_ms = 0;
    bit [7:0]    prog[$];

    always #2 aclk = ~aclk;

    led_strip_macro_sequencer u_top (.*);

    lsms_checker u_chk (.*);

    // result side: random stalls plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 0;
        end else if (hold_req) begin
            hold_req = 0;
            hold_left = 400;
            m_ready <= 0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 8);
            m_ready <= 0;
        end else begin
            m_ready <= 1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic put_item(func_t f, bit [7:0] a, bit [7:0] b, bit [31:0] t);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1;
        s_func <= f;
        s_prog_addr <= a;
        s_prog_byte <= b;
        s_now_ms <= t;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic tick();
        case ($urandom_range(0, 19))
            0:       now_ms = $urandom();
            1, 2, 3: now_ms += $urandom_range(0, 4000);
            default: now_ms += $urandom_range(0, 60);
        endcase
        put_item(FUNC_TICK, 8'($urandom()), 8'($urandom()), now_ms);
    endtask

    // wait for every expected result, then let the block settle
    task automatic drain();
        s_valid <= 0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(bit idx, bit [8:0] data);
        cfg_wen <= 1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wen <= 0;
    endtask

    task automatic load_prog();
        foreach (prog[i]) put_item(FUNC_LOAD, 8'(i), prog[i], $urandom());
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) prog.push_back(s[i]);
    endfunction

    // operand digits: sometimes missing, sometimes long enough to saturate
    function automatic void add_num(int unsigned hi);
        case ($urandom_range(0, 9))
            0:       ;
            1:       add_text($sformatf("%0d", $urandom_range(10000, 999999)));
            default: add_text($sformatf("%0d", $urandom_range(0, hi)));
        endcase
    endfunction

    function automatic void build_program(int target);
        bit [7:0] presets[9] = '{CH_LR, CH_LG, CH_LB, CH_LW, CH_LY, CH_LO, CH_LP,
                                 CH_LC, CH_LV};
        prog.delete();
        while (prog.size() < target) begin
            case ($urandom_range(0, 31))
                0, 1:   begin prog.push_back(CH_S); add_num(70); end
                2, 3:   begin prog.push_back(CH_E); add_num(70); end
                4, 5:   begin
                    prog.push_back(CH_L);
                    prog.push_back(($urandom_range(0, 5) == 0) ? 8'($urandom())
                                   : presets[$urandom_range(0, 8)]);
                end
                6:      begin prog.push_back(CH_R); add_num(999); end
                7:      begin prog.push_back(CH_G); add_num(999); end
                8:      begin prog.push_back(CH_B); add_num(999); end
                9:      begin prog.push_back(CH_D); add_num(1); end
                10, 11: begin prog.push_back(CH_X); add_num(200); end
                12, 13: prog.push_back(CH_W);
                14, 15: prog.push_back(CH_Z);
                16, 17: prog.push_back(CH_A);
                18, 19: prog.push_back(CH_C);
                20, 21, 22: prog.push_back(CH_O);
                23, 24: prog.push_back(CH_N);
                25:     prog.push_back(CH_STOP);
                26:     prog.push_back(8'($urandom()));
                default: prog.push_back(CH_REP);
            endcase
        end
        if ($urandom_range(0, 2) != 0) prog.push_back(CH_REP);
    endfunction

    // one random phase: configure, load, start, then mostly ticks with noise
    task automatic run_phase(bit [8:0] leds, bit [8:0] len_override, int n_items,
                             bit pause_mid);
        int len;
        drain();
        len = prog.size() - (($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 0);
        if (len < 0) len = 0;
        write_reg(CFG_LED_COUNT, leds);
        write_reg(CFG_PROG_LEN, (len_override != 0) ? len_override : 9'(len));
        load_prog();
        put_item(FUNC_START, 8'($urandom()), 8'($urandom()), now_ms);
        for (int i = 0; i < n_items; i++) begin
            if (pause_mid && i == n_items / 2) begin
                s_valid <= 0;
                do @(posedge aclk); while (pending != 0);
            end
            case ($urandom_range(0, 24))
                0: put_item(FUNC_LOAD, 8'($urandom()), 8'($urandom()), $urandom());
                1: put_item(FUNC_NONE, 8'($urandom()), 8'($urandom()), $urandom());
                2: put_item(FUNC_START, 8'($urandom()), 8'($urandom()), now_ms);
                default: tick();
            endcase
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: nothing configured, unknown opcode at reset, ignored function
        put_item(FUNC_TICK, 8'hff, 8'hff, 32'hffff_ffff);
        put_item(FUNC_NONE, 8'h00, 8'h00, 32'h0);
        put_item(FUNC_START, 8'h00, 8'h00, 32'h0);
        put_item(FUNC_TICK, 8'h00, 8'h00, 32'h0);
        drain();

        // directed program: ranges, presets, components, long and missing numbers,
        // out-of-strip range, wait, clear, fill, repeat
        prog.delete();
        add_text("S1E5LpOR1G22B99999AS70CX3WBLzZ*");
        write_reg(CFG_LED_COUNT, 8);
        write_reg(CFG_PROG_LEN, 9'(prog.size()));
        load_prog();
        now_ms = 0;
        put_item(FUNC_START, 0, 0, now_ms);
        repeat (16) begin
            now_ms += 2;
            put_item(FUNC_TICK, 0, 0, now_ms);
        end

        // random phases over the configuration extremes
        build_program($urandom_range(5, 16));
        run_phase(1, 0, 15, 0);
        build_program($urandom_range(5, 16));
        drain();
        hold_req = 1;
        run_phase(64, 0, 18, 0);
        build_program($urandom_range(5, 16));
        run_phase(127, 0, 16, 1);
        build_program($urandom_range(5, 16));
        run_phase(0, 0, 12, 0);
        build_program($urandom_range(5, 16));
        run_phase(9'($urandom_range(2, 63)), 0, 15, 0);
        build_program($urandom_range(5, 16));
        drain();
        quiet = 1;
        run_phase(9'($urandom_range(2, 63)), 0, 20, 0);

        drain();
        if (errors == 0 && pending == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
src/lsms_pkg.sv
src/lsms_ram.sv
src/lsms_ctrl.sv
src/lsms_dp.sv
src/led_strip_macro_sequencer.sv
src/lsms_checker.sv
sim/lsms_checker.sv
sim/led_strip_macro_sequencer_tb.sv
